[sv/cnp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cnp_pkg;

    // Parse phases, one-hot.
    typedef enum logic [6:0] {
        PH_HDR   = 7'b0000001,
        PH_NAME  = 7'b0000010,
        PH_NPAD  = 7'b0000100,
        PH_DATA  = 7'b0001000,
        PH_DPAD  = 7'b0010000,
        PH_TRAIL = 7'b0100000,
        PH_BAD   = 7'b1000000
    } phase_t;

    // Region codes as seen on the output.
    localparam logic [2:0] RGN_HDR   = 3'd0;
    localparam logic [2:0] RGN_NAME  = 3'd1;
    localparam logic [2:0] RGN_NPAD  = 3'd2;
    localparam logic [2:0] RGN_DATA  = 3'd3;
    localparam logic [2:0] RGN_DPAD  = 3'd4;
    localparam logic [2:0] RGN_TRAIL = 3'd5;
    localparam logic [2:0] RGN_BAD   = 3'd6;

    // Header byte positions.
    localparam logic [6:0] MAGIC_LEN = 7'd6;
    localparam logic [6:0] MODE_AT   = 7'd14;
    localparam logic [6:0] MODE_END  = 7'd21;
    localparam logic [6:0] FSIZE_AT  = 7'd54;
    localparam logic [6:0] FSIZE_END = 7'd61;
    localparam logic [6:0] NSIZE_AT  = 7'd94;
    localparam logic [6:0] NSIZE_END = 7'd101;
    localparam logic [6:0] HDR_LAST  = 7'd109;

    // Name index of the closing NUL of the trailer name, and the saturated index.
    localparam logic [3:0] TRAILER_LAST = 4'd10;
    localparam logic [3:0] NAME_IDX_SAT = 4'd11;

    localparam logic [15:0] ENTRY_MAX = 16'hFFFF;

    // One result item.
    typedef struct packed {
        logic        trailer_found;
        logic        magic_error;
        logic        entry_last;
        logic [3:0]  type_bits;
        logic [31:0] data_length;
        logic [31:0] name_length;
        logic [15:0] entry_number;
        logic [2:0]  region;
        logic [7:0]  byte_out;
    } result_t;

    // Expected magic character at header position idx (0 to 5).
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                3'd0:    ch = "0";
                3'd1:    ch = "7";
                3'd2:    ch = "0";
                3'd3:    ch = "7";
                3'd4:    ch = "0";
                3'd5:    ch = "1";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // Expected character of the trailer name at index idx, NUL at the end.
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] ch;
        begin
            case (idx)
                4'd0:    ch = "T";
                4'd1:    ch = "R";
                4'd2:    ch = "A";
                4'd3:    ch = "I";
                4'd4:    ch = "L";
                4'd5:    ch = "E";
                4'd6:    ch = "R";
                4'd7:    ch = "!";
                4'd8:    ch = "!";
                4'd9:    ch = "!";
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

    // Hex character decode: bit 4 is set for a valid digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [7:0] t;
        logic [4:0] r;
        begin
            t = 8'h00;
            r = 5'b0;
            if (ch >= "0" && ch <= "9")
            begin
                t = ch - 8'h30;
                r = {1'b1, t[3:0]};
            end
            else if (ch >= "A" && ch <= "F")
            begin
                t = ch - 8'h37;
                r = {1'b1, t[3:0]};
            end
            else if (ch >= "a" && ch <= "f")
            begin
                t = ch - 8'h57;
                r = {1'b1, t[3:0]};
            end
            return r;
        end
    endfunction

    // Output region code for a phase.
    function automatic logic [2:0] region_code(input phase_t ph);
        logic [2:0] r;
        begin
            case (ph)
                PH_HDR:   r = RGN_HDR;
                PH_NAME:  r = RGN_NAME;
                PH_NPAD:  r = RGN_NPAD;
                PH_DATA:  r = RGN_DATA;
                PH_DPAD:  r = RGN_DPAD;
                PH_TRAIL: r = RGN_TRAIL;
                PH_BAD:   r = RGN_BAD;
                default:  r = RGN_HDR;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

[sv/cnp_parse_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module cnp_parse_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       byte_value,
    output cnp_pkg::result_t      result
);

    // Outcome of moving on to the next non-empty region.
    typedef struct packed {
        cnp_pkg::phase_t phase;
        logic [31:0]     region_count;
        logic            load_count;
        logic            trailer_reset;
        logic            entry_inc;
        logic            last;
    } settle_t;

    // Enter the first non-empty region at or after the requested one.
    function automatic settle_t settle(input cnp_pkg::phase_t nxt_in,
                                       input logic [31:0] ns,
                                       input logic [31:0] fs,
                                       input logic [1:0] ol);
        settle_t         r;
        cnp_pkg::phase_t nxt;
        logic            done;
        begin
            nxt             = nxt_in;
            done            = 1'b0;
            r.phase         = cnp_pkg::PH_HDR;
            r.region_count  = 32'd0;
            r.load_count    = 1'b0;
            r.trailer_reset = 1'b0;
            r.entry_inc     = 1'b0;
            r.last          = 1'b0;
            if (nxt == cnp_pkg::PH_NAME)
            begin
                if (ns != 32'd0)
                begin
                    r.phase         = cnp_pkg::PH_NAME;
                    r.region_count  = ns;
                    r.load_count    = 1'b1;
                    r.trailer_reset = 1'b1;
                    done            = 1'b1;
                end
                else
                begin
                    nxt = cnp_pkg::PH_NPAD;
                end
            end
            if (!done && nxt == cnp_pkg::PH_NPAD)
            begin
                if (ol != 2'd0)
                begin
                    r.phase = cnp_pkg::PH_NPAD;
                    done    = 1'b1;
                end
                else
                begin
                    nxt = cnp_pkg::PH_DATA;
                end
            end
            if (!done && nxt == cnp_pkg::PH_DATA)
            begin
                if (fs != 32'd0)
                begin
                    r.phase        = cnp_pkg::PH_DATA;
                    r.region_count = fs;
                    r.load_count   = 1'b1;
                    done           = 1'b1;
                end
                else
                begin
                    nxt = cnp_pkg::PH_DPAD;
                end
            end
            if (!done && nxt == cnp_pkg::PH_DPAD && ol != 2'd0)
            begin
                r.phase = cnp_pkg::PH_DPAD;
                done    = 1'b1;
            end
            // Nothing left in this entry: back to the next header.
            if (!done)
            begin
                r.phase         = cnp_pkg::PH_HDR;
                r.region_count  = 32'd0;
                r.load_count    = 1'b1;
                r.trailer_reset = 1'b1;
                r.entry_inc     = 1'b1;
                r.last          = 1'b1;
            end
            return r;
        end
    endfunction

    cnp_pkg::phase_t phase_reg, phase_next;
    logic [31:0]     region_count_reg, region_count_next;
    logic [31:0]     hex_accum_reg, hex_accum_next;
    logic            hex_stopped_reg, hex_stopped_next;
    logic [31:0]     name_size_reg, name_size_next;
    logic [31:0]     file_size_reg, file_size_next;
    logic [3:0]      mode_type_reg, mode_type_next;
    logic [1:0]      offset_low_reg, offset_low_next;
    logic            trailer_match_reg, trailer_match_next;
    logic [3:0]      name_idx_reg, name_idx_next;
    logic [15:0]     entry_count_reg, entry_count_next;

    logic [6:0]      hdr_pos;
    logic            field_start;
    logic            in_field;
    logic [31:0]     acc_base;
    logic            stop_base;
    logic [4:0]      hex_dec;
    logic            name_miss;
    logic [31:0]     count_dec;
    logic            last;
    settle_t         st;

    assign hdr_pos   = region_count_reg[6:0];
    assign count_dec = region_count_reg - 32'd1;
    assign hex_dec   = cnp_pkg::hex_digit(byte_value);

    // Hex field windows inside the header.
    always_comb
    begin
        field_start = (hdr_pos == cnp_pkg::MODE_AT) || (hdr_pos == cnp_pkg::FSIZE_AT)
                      || (hdr_pos == cnp_pkg::NSIZE_AT);
        in_field    = (hdr_pos >= cnp_pkg::MODE_AT && hdr_pos <= cnp_pkg::MODE_END)
                      || (hdr_pos >= cnp_pkg::FSIZE_AT && hdr_pos <= cnp_pkg::FSIZE_END)
                      || (hdr_pos >= cnp_pkg::NSIZE_AT && hdr_pos <= cnp_pkg::NSIZE_END);
        acc_base    = field_start ? 32'd0 : hex_accum_reg;
        stop_base   = field_start ? 1'b0 : hex_stopped_reg;
        name_miss   = (name_idx_reg >= cnp_pkg::NAME_IDX_SAT)
                      || (byte_value != cnp_pkg::trailer_char(name_idx_reg));
    end

    // Next-state logic for one byte.
    always_comb
    begin
        phase_next         = phase_reg;
        region_count_next  = region_count_reg;
        hex_accum_next     = hex_accum_reg;
        hex_stopped_next   = hex_stopped_reg;
        name_size_next     = name_size_reg;
        file_size_next     = file_size_reg;
        mode_type_next     = mode_type_reg;
        offset_low_next    = offset_low_reg;
        trailer_match_next = trailer_match_reg;
        name_idx_next      = name_idx_reg;
        entry_count_next   = entry_count_reg;
        last               = 1'b0;
        st                 = settle(cnp_pkg::PH_HDR, name_size_reg, file_size_reg,
                                    offset_low_reg);
        case (phase_reg)
            cnp_pkg::PH_HDR:
            begin
                if (hdr_pos < cnp_pkg::MAGIC_LEN
                    && byte_value != cnp_pkg::magic_char(hdr_pos[2:0]))
                begin
                    phase_next = cnp_pkg::PH_BAD;
                end
                else
                begin
                    if (in_field)
                    begin
                        hex_accum_next   = acc_base;
                        hex_stopped_next = stop_base;
                        if (!stop_base)
                        begin
                            if (hex_dec[4])
                            begin
                                hex_accum_next = {acc_base[27:0], hex_dec[3:0]};
                            end
                            else
                            begin
                                hex_stopped_next = 1'b1;
                            end
                        end
                    end
                    if (hdr_pos == cnp_pkg::MODE_END)
                    begin
                        mode_type_next = hex_accum_next[15:12];
                    end
                    else if (hdr_pos == cnp_pkg::FSIZE_END)
                    begin
                        file_size_next = hex_accum_next;
                    end
                    else if (hdr_pos == cnp_pkg::NSIZE_END)
                    begin
                        name_size_next = hex_accum_next;
                    end
                    offset_low_next = offset_low_reg + 2'd1;
                    if (hdr_pos == cnp_pkg::HDR_LAST)
                    begin
                        st = settle(cnp_pkg::PH_NAME, name_size_reg, file_size_reg,
                                    offset_low_next);
                    end
                    else
                    begin
                        region_count_next = {25'd0, hdr_pos + 7'd1};
                    end
                end
            end
            cnp_pkg::PH_NAME:
            begin
                if (name_miss)
                begin
                    trailer_match_next = 1'b0;
                end
                if (name_idx_reg != cnp_pkg::NAME_IDX_SAT)
                begin
                    name_idx_next = name_idx_reg + 4'd1;
                end
                offset_low_next   = offset_low_reg + 2'd1;
                region_count_next = count_dec;
                if (count_dec == 32'd0)
                begin
                    if (trailer_match_next && name_idx_reg == cnp_pkg::TRAILER_LAST)
                    begin
                        phase_next = cnp_pkg::PH_TRAIL;
                        last       = 1'b1;
                    end
                    else
                    begin
                        st = settle(cnp_pkg::PH_NPAD, name_size_reg, file_size_reg,
                                    offset_low_next);
                    end
                end
            end
            cnp_pkg::PH_NPAD:
            begin
                offset_low_next = offset_low_reg + 2'd1;
                if (offset_low_next == 2'd0)
                begin
                    st = settle(cnp_pkg::PH_DATA, name_size_reg, file_size_reg,
                                offset_low_next);
                end
            end
            cnp_pkg::PH_DATA:
            begin
                offset_low_next   = offset_low_reg + 2'd1;
                region_count_next = count_dec;
                if (count_dec == 32'd0)
                begin
                    st = settle(cnp_pkg::PH_DPAD, name_size_reg, file_size_reg,
                                offset_low_next);
                end
            end
            cnp_pkg::PH_DPAD:
            begin
                offset_low_next = offset_low_reg + 2'd1;
                if (offset_low_next == 2'd0)
                begin
                    st = settle(cnp_pkg::PH_HDR, name_size_reg, file_size_reg,
                                offset_low_next);
                end
            end
            default:
            begin
                // Halted after the trailer or a bad magic.
            end
        endcase

        // Apply a region change when one was taken above.
        if (st.last || st.load_count || st.phase != cnp_pkg::PH_HDR)
        begin
            if (phase_reg != cnp_pkg::PH_TRAIL && phase_reg != cnp_pkg::PH_BAD
                && !(phase_reg == cnp_pkg::PH_HDR && hdr_pos != cnp_pkg::HDR_LAST)
                && !(phase_reg == cnp_pkg::PH_NAME && count_dec != 32'd0)
                && !(phase_reg == cnp_pkg::PH_DATA && count_dec != 32'd0)
                && !((phase_reg == cnp_pkg::PH_NPAD || phase_reg == cnp_pkg::PH_DPAD)
                     && offset_low_next != 2'd0)
                && phase_next != cnp_pkg::PH_TRAIL && phase_next != cnp_pkg::PH_BAD)
            begin
                phase_next = st.phase;
                last       = st.last;
                if (st.load_count)
                begin
                    region_count_next = st.region_count;
                end
                if (st.trailer_reset)
                begin
                    trailer_match_next = 1'b1;
                    name_idx_next      = 4'd0;
                end
                if (st.entry_inc && entry_count_reg != cnp_pkg::ENTRY_MAX)
                begin
                    entry_count_next = entry_count_reg + 16'd1;
                end
            end
        end
    end

    // Result fields for the byte at the input.
    always_comb
    begin
        result.byte_out      = byte_value;
        result.region        = cnp_pkg::region_code(phase_reg);
        result.entry_number  = entry_count_reg;
        result.name_length   = name_size_next;
        result.data_length   = file_size_next;
        result.type_bits     = mode_type_next;
        result.entry_last    = last;
        result.magic_error   = (phase_next == cnp_pkg::PH_BAD);
        result.trailer_found = (phase_next == cnp_pkg::PH_TRAIL);
    end

    // Parse state advances once per byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= cnp_pkg::PH_HDR;
            region_count_reg  <= 32'd0;
            hex_accum_reg     <= 32'd0;
            hex_stopped_reg   <= 1'b0;
            name_size_reg     <= 32'd0;
            file_size_reg     <= 32'd0;
            mode_type_reg     <= 4'd0;
            offset_low_reg    <= 2'd0;
            trailer_match_reg <= 1'b1;
            name_idx_reg      <= 4'd0;
            entry_count_reg   <= 16'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            region_count_reg  <= region_count_next;
            hex_accum_reg     <= hex_accum_next;
            hex_stopped_reg   <= hex_stopped_next;
            name_size_reg     <= name_size_next;
            file_size_reg     <= file_size_next;
            mode_type_reg     <= mode_type_next;
            offset_low_reg    <= offset_low_next;
            trailer_match_reg <= trailer_match_next;
            name_idx_reg      <= name_idx_next;
            entry_count_reg   <= entry_count_next;
        end
    end

endmodule

`default_nettype wire

[sv/cpio_newc_stream_parser.sv]
// Path: an input transfer passes through the input register and then the output register.
// Throughput: one byte per cycle unless the output stalls; input and output registers each
// hold one byte, and the parse state updates once per byte as it moves between them.
// Reset: rst_n is asynchronous and active low; it empties both registers and returns
// the parser to the start of a header with entry number zero.
`timescale 1ns / 1ps
`default_nettype none

module cpio_newc_stream_parser
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // byte_value[7:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // byte_out[7:0], entry_number[23:8], name_length[55:24], data_length[87:56],
    // type_bits[91:88], magic_error[92], trailer_found[93], zero[95:94]
    output logic [95:0]       m_axis_tdata,
    output logic [2:0]        m_axis_tuser,   // region[2:0]
    output logic              m_axis_tlast    // entry_last
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    cnp_pkg::result_t out_data_reg;
    cnp_pkg::result_t core_result;
    logic             step;

    // A byte moves to the output when the output register is empty or being drained.
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    cnp_parse_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (in_byte_reg),
        .result     (core_result)
    );

    // Input and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step)
        begin
            out_data_reg <= core_result;
        end
    end

    // Output transfer fields.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.region;
    assign m_axis_tlast  = out_data_reg.entry_last;
    assign m_axis_tdata  = {2'b00,
                            out_data_reg.trailer_found,
                            out_data_reg.magic_error,
                            out_data_reg.type_bits,
                            out_data_reg.data_length,
                            out_data_reg.name_length,
                            out_data_reg.entry_number,
                            out_data_reg.byte_out};

endmodule

`default_nettype wire

[tb/tb_cpio_newc_stream_parser.sv]
`timescale 1ns / 1ps

module tb_cpio_newc_stream_parser;

    // Cycles without any transfer on either side before the run is abandoned.
    localparam int IDLE_LIMIT = 1000;

    // Text constants of the archive format, first character in the top byte.
    localparam logic [47:0] MAGIC_TEXT   = "070701";
    localparam logic [87:0] TRAILER_TEXT = {"TRAILER!!!", 8'h00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // byte_value[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // byte_out[7:0], entry_number[23:8], name_length[55:24], data_length[87:56],
    // type_bits[91:88], magic_error[92], trailer_found[93], zero[95:94]
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;             // region[2:0]
    logic        m_axis_tlast;             // entry_last

    cpio_newc_stream_parser DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the parser state.
    logic [2:0]  shadow_region;
    logic [31:0] shadow_count;
    logic [31:0] shadow_accum;
    bit          shadow_hex_done;
    logic [31:0] shadow_name_size;
    logic [31:0] shadow_file_size;
    logic [3:0]  shadow_type;
    logic [1:0]  shadow_offset;
    bit          shadow_trailer_ok;
    logic [15:0] shadow_entry;

    // Tags expected on the output, oldest first.
    cnp_pkg::result_t expected_tags[$];
    logic [7:0]       pending_name[$];

    int          mismatches = 0;
    int          tags_checked = 0;
    int          idle_cycles = 0;
    int          bytes_sent = 0;
    int          entries_sent = 0;
    int          gen_offset = 0;
    int          burst_left = 0;
    bit          tx_gaps_on = 1'b0;
    int          rx_mode = 0;
    int          rx_tick = 0;
    bit          ended_on_trailer = 1'b0;

    function automatic logic [7:0] magic_at(input int pos);
        magic_at = MAGIC_TEXT[8 * (5 - pos) +: 8];
    endfunction

    function automatic logic [7:0] trailer_at(input int pos);
        trailer_at = TRAILER_TEXT[8 * (10 - pos) +: 8];
    endfunction

    function automatic bit is_hex_char(input logic [7:0] ch);
        is_hex_char = (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "F") ||
                      (ch >= "a" && ch <= "f");
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
        logic [7:0] v;
        if (ch <= "9")
            v = ch - "0";
        else if (ch <= "F")
            v = ch - "A" + 8'd10;
        else
            v = ch - "a" + 8'd10;
        hex_nibble = v[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            hex_char = 8'h30 + nib;
        else
            hex_char = (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    function automatic int hex_width(input logic [31:0] v);
        int w;
        w = 0;
        while (v != 32'd0)
        begin
            w++;
            v = v >> 4;
        end
        return w;
    endfunction

    function automatic logic [7:0] any_byte();
        any_byte = 8'($urandom_range(0, 255));
    endfunction

    // Move into the first non-empty region at or after the given one.
    // Returns 1 when every remaining region was empty and the entry is over.
    function automatic bit open_region(input logic [2:0] start);
        logic [2:0] want;
        want = start;
        if (want == cnp_pkg::RGN_NAME)
        begin
            if (shadow_name_size != 32'd0)
            begin
                shadow_region = cnp_pkg::RGN_NAME;
                shadow_count = shadow_name_size;
                shadow_trailer_ok = 1'b1;
                return 1'b0;
            end
            want = cnp_pkg::RGN_NPAD;
        end
        if (want == cnp_pkg::RGN_NPAD)
        begin
            if (shadow_offset != 2'd0)
            begin
                shadow_region = cnp_pkg::RGN_NPAD;
                return 1'b0;
            end
            want = cnp_pkg::RGN_DATA;
        end
        if (want == cnp_pkg::RGN_DATA)
        begin
            if (shadow_file_size != 32'd0)
            begin
                shadow_region = cnp_pkg::RGN_DATA;
                shadow_count = shadow_file_size;
                return 1'b0;
            end
            want = cnp_pkg::RGN_DPAD;
        end
        if (want == cnp_pkg::RGN_DPAD && shadow_offset != 2'd0)
        begin
            shadow_region = cnp_pkg::RGN_DPAD;
            return 1'b0;
        end
        // Entry finished: back to a fresh header.
        shadow_region = cnp_pkg::RGN_HDR;
        shadow_count = 32'd0;
        shadow_trailer_ok = 1'b1;
        if (shadow_entry != cnp_pkg::ENTRY_MAX)
            shadow_entry = shadow_entry + 16'd1;
        return 1'b1;
    endfunction

    // Tag one archive byte and advance the shadow state.
    task automatic classify_byte(input logic [7:0] b, output cnp_pkg::result_t tag);
        logic [2:0]  region_now;
        logic [15:0] entry_now;
        logic [31:0] pos;
        bit          last;
        region_now = shadow_region;
        entry_now = shadow_entry;
        last = 1'b0;
        case (shadow_region)
            cnp_pkg::RGN_HDR:
            begin
                pos = shadow_count;
                if (pos < cnp_pkg::MAGIC_LEN && b != magic_at(pos))
                begin
                    shadow_region = cnp_pkg::RGN_BAD;
                end
                else
                begin
                    if (pos == cnp_pkg::MODE_AT || pos == cnp_pkg::FSIZE_AT ||
                        pos == cnp_pkg::NSIZE_AT)
                    begin
                        shadow_accum = 32'd0;
                        shadow_hex_done = 1'b0;
                    end
                    if (((pos >= cnp_pkg::MODE_AT && pos <= cnp_pkg::MODE_END) ||
                         (pos >= cnp_pkg::FSIZE_AT && pos <= cnp_pkg::FSIZE_END) ||
                         (pos >= cnp_pkg::NSIZE_AT && pos <= cnp_pkg::NSIZE_END)) &&
                        !shadow_hex_done)
                    begin
                        // Decoding of a field ends at its first non-hex character.
                        if (is_hex_char(b))
                            shadow_accum = {shadow_accum[27:0], hex_nibble(b)};
                        else
                            shadow_hex_done = 1'b1;
                    end
                    if (pos == cnp_pkg::MODE_END)
                        shadow_type = shadow_accum[15:12];
                    else if (pos == cnp_pkg::FSIZE_END)
                        shadow_file_size = shadow_accum;
                    else if (pos == cnp_pkg::NSIZE_END)
                        shadow_name_size = shadow_accum;
                    shadow_offset = shadow_offset + 2'd1;
                    if (pos == cnp_pkg::HDR_LAST)
                        last = open_region(cnp_pkg::RGN_NAME);
                    else
                        shadow_count = pos + 32'd1;
                end
            end
            cnp_pkg::RGN_NAME:
            begin
                pos = shadow_name_size - shadow_count;
                if (pos >= cnp_pkg::NAME_IDX_SAT || b != trailer_at(pos))
                    shadow_trailer_ok = 1'b0;
                shadow_offset = shadow_offset + 2'd1;
                shadow_count = shadow_count - 32'd1;
                if (shadow_count == 32'd0)
                begin
                    if (shadow_trailer_ok && pos == cnp_pkg::TRAILER_LAST)
                    begin
                        shadow_region = cnp_pkg::RGN_TRAIL;
                        last = 1'b1;
                    end
                    else
                    begin
                        last = open_region(cnp_pkg::RGN_NPAD);
                    end
                end
            end
            cnp_pkg::RGN_NPAD:
            begin
                shadow_offset = shadow_offset + 2'd1;
                if (shadow_offset == 2'd0)
                    last = open_region(cnp_pkg::RGN_DATA);
            end
            cnp_pkg::RGN_DATA:
            begin
                shadow_offset = shadow_offset + 2'd1;
                shadow_count = shadow_count - 32'd1;
                if (shadow_count == 32'd0)
                    last = open_region(cnp_pkg::RGN_DPAD);
            end
            cnp_pkg::RGN_DPAD:
            begin
                shadow_offset = shadow_offset + 2'd1;
                if (shadow_offset == 2'd0)
                    last = open_region(cnp_pkg::RGN_HDR);
            end
            default:
            begin
            end
        endcase
        tag.byte_out = b;
        tag.region = region_now;
        tag.entry_number = entry_now;
        tag.name_length = shadow_name_size;
        tag.data_length = shadow_file_size;
        tag.type_bits = shadow_type;
        tag.entry_last = last;
        tag.magic_error = (shadow_region == cnp_pkg::RGN_BAD);
        tag.trailer_found = (shadow_region == cnp_pkg::RGN_TRAIL);
    endtask

    // Offer one byte on the input stream, in bursts with random gaps between them when tx_gaps_on is set.
    task automatic send_byte(input logic [7:0] b);
        cnp_pkg::result_t tag;
        int               gap;
        if (burst_left == 0)
        begin
            gap = tx_gaps_on ? $urandom_range(1, 5) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        classify_byte(b, tag);
        expected_tags.push_back(tag);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        gen_offset++;
        bytes_sent++;
    endtask

    // Eight-character field: the given number of hex digits of value, then, if that is fewer than
    // eight, a stop character and arbitrary bytes that the parser must ignore.
    task automatic send_hex_field(input logic [31:0] value, input int digits);
        logic [7:0] ch;
        int         k;
        for (k = 0; k < 8; k++)
        begin
            if (k < digits)
            begin
                ch = hex_char(value[4 * (digits - 1 - k) +: 4], 1'($urandom_range(0, 1)));
            end
            else if (k == digits)
            begin
                do
                    ch = any_byte();
                while (is_hex_char(ch));
            end
            else
            begin
                ch = any_byte();
            end
            send_byte(ch);
        end
    endtask

    // Padding up to the next 4-byte offset, mostly zero bytes.
    task automatic send_padding();
        int n;
        n = (4 - (gen_offset % 4)) % 4;
        repeat (n)
            send_byte(($urandom_range(0, 3) == 0) ? any_byte() : 8'h00);
    endtask

    // One complete entry; the name comes from pending_name where it is filled.
    task automatic send_entry(input logic [31:0] mode_val, input int mode_digits,
                              input int name_size, input int name_digits,
                              input int file_size, input int file_digits);
        int k;
        for (k = 0; k < cnp_pkg::MAGIC_LEN; k++)
            send_byte(magic_at(k));
        for (k = cnp_pkg::MAGIC_LEN; k < cnp_pkg::MODE_AT; k++)
            send_byte(any_byte());
        send_hex_field(mode_val, mode_digits);
        for (k = cnp_pkg::MODE_END + 1; k < cnp_pkg::FSIZE_AT; k++)
            send_byte(any_byte());
        send_hex_field(file_size, file_digits);
        for (k = cnp_pkg::FSIZE_END + 1; k < cnp_pkg::NSIZE_AT; k++)
            send_byte(any_byte());
        send_hex_field(name_size, name_digits);
        for (k = cnp_pkg::NSIZE_END + 1; k <= cnp_pkg::HDR_LAST; k++)
            send_byte(any_byte());
        for (k = 0; k < name_size; k++)
            send_byte((pending_name.size() != 0) ? pending_name.pop_front() : any_byte());
        pending_name.delete();
        send_padding();
        for (k = 0; k < file_size; k++)
            send_byte(any_byte());
        send_padding();
        entries_sent++;
    endtask

    // Queue a name built on the trailer text, with one character changed at flip_at.
    task automatic load_trailer_name(input int len, input int flip_at);
        logic [7:0] ch;
        int         k;
        pending_name.delete();
        for (k = 0; k < len; k++)
        begin
            ch = (k <= cnp_pkg::TRAILER_LAST) ? trailer_at(k) : any_byte();
            if (k == flip_at)
                ch = ch ^ 8'h20;
            pending_name.push_back(ch);
        end
    endtask

    // Compare one output transfer with the oldest expected tag.
    task automatic compare_tag();
        cnp_pkg::result_t want;
        cnp_pkg::result_t got;
        got.byte_out = m_axis_tdata[7:0];
        got.entry_number = m_axis_tdata[23:8];
        got.name_length = m_axis_tdata[55:24];
        got.data_length = m_axis_tdata[87:56];
        got.type_bits = m_axis_tdata[91:88];
        got.magic_error = m_axis_tdata[92];
        got.trailer_found = m_axis_tdata[93];
        got.region = m_axis_tuser;
        got.entry_last = m_axis_tlast;
        tags_checked++;
        if (expected_tags.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected output transfer: byte=%02h region=%0d", got.byte_out,
                         got.region);
            return;
        end
        want = expected_tags.pop_front();
        if (got.byte_out !== want.byte_out || got.region !== want.region ||
            got.entry_number !== want.entry_number || got.name_length !== want.name_length ||
            got.data_length !== want.data_length || got.type_bits !== want.type_bits ||
            got.entry_last !== want.entry_last || got.magic_error !== want.magic_error ||
            got.trailer_found !== want.trailer_found)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch on output byte %0d:", tags_checked);
                $write("  expected byte=%02h region=%0d entry=%0d nlen=%0d dlen=%0d",
                       want.byte_out, want.region, want.entry_number, want.name_length,
                       want.data_length);
                $display(" type=%0d last=%b merr=%b trl=%b", want.type_bits,
                         want.entry_last, want.magic_error, want.trailer_found);
                $write("  actual   byte=%02h region=%0d entry=%0d nlen=%0d dlen=%0d",
                       got.byte_out, got.region, got.entry_number, got.name_length,
                       got.data_length);
                $display(" type=%0d last=%b merr=%b trl=%b", got.type_bits,
                         got.entry_last, got.magic_error, got.trailer_found);
            end
        end
    endtask

    // Output side: check each transfer, then pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            compare_tag();
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            default: m_axis_tready <= ((rx_tick % 7) >= 3);
        endcase
    end

    // Watchdog on transfers at either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Ordinary entries of a regular file and a symlink, the first with no idling at all.
    task automatic test_plain_entries();
        tx_gaps_on = 1'b0;
        rx_mode = 0;
        send_entry(32'h000081A4, 8, 5, 8, 12, 8);
        tx_gaps_on = 1'b1;
        rx_mode = 1;
        send_entry(32'h0000A1FF, 8, 8, 8, 7, 8);
    endtask

    // Entries where the name, the data or the padding is empty.
    task automatic test_empty_regions();
        rx_mode = 2;
        send_entry(32'h000041ED, 8, 0, 8, 0, 8);
        send_entry(32'h000081A4, 8, 1, 8, 4, 8);
    endtask

    // Hex fields in mixed case, stopped early, or stopped at the first character.
    task automatic test_hex_fields();
        rx_mode = 1;
        send_entry(32'h0000A, 5, 7, 1, 0, 0);
    endtask

    // Names close to the trailer name that must not stop the parser.
    task automatic test_near_trailers();
        rx_mode = 0;
        load_trailer_name(11, 9);
        send_entry(32'h000081A4, 8, 11, 1, 2, 8);
        load_trailer_name(11, 10);
        send_entry(32'h000081A4, 8, 11, 8, 0, 8);
        load_trailer_name(10, -1);
        send_entry(32'h000081A4, 8, 10, 8, 1, 8);
    endtask

    // Well-formed entries with random content, sizes and field encodings.
    task automatic test_random_archive();
        int          start;
        int          name_size;
        int          file_size;
        int          mode_digits;
        logic [31:0] mode_val;
        start = bytes_sent;
        while (bytes_sent - start < 100)
        begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode = $urandom_range(0, 2);
            name_size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1:    file_size = 0;
                2:       file_size = $urandom_range(65, 300);
                default: file_size = $urandom_range(1, 64);
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       mode_val = 32'h000041ED;
                    1:       mode_val = 32'h000081A4;
                    default: mode_val = 32'h0000A1FF;
                endcase
                mode_digits = 8;
            end
            else
            begin
                mode_val = $urandom;
                mode_digits = $urandom_range(0, 8);
                if (mode_digits < 8)
                    mode_val = mode_val & ((32'd1 << (4 * mode_digits)) - 32'd1);
            end
            send_entry(mode_val, mode_digits,
                       name_size, $urandom_range(hex_width(name_size), 8),
                       file_size, $urandom_range(hex_width(file_size), 8));
        end
    endtask

    // Stop the parser for good, by a trailer entry or a broken magic.
    task automatic test_halt();
        int         k;
        int         broken_at;
        tx_gaps_on = 1'b1;
        rx_mode = 1;
        ended_on_trailer = 1'($urandom_range(0, 1));
        if (ended_on_trailer)
        begin
            load_trailer_name(11, -1);
            send_entry(32'h00000000, 8, 11, $urandom_range(1, 8), $urandom_range(0, 8), 8);
        end
        else
        begin
            broken_at = $urandom_range(0, cnp_pkg::MAGIC_LEN - 1);
            for (k = 0; k < broken_at; k++)
                send_byte(magic_at(k));
            send_byte(magic_at(broken_at) ^ 8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(8, 40))
            send_byte(any_byte());
    endtask

    initial
    begin
        shadow_region = cnp_pkg::RGN_HDR;
        shadow_count = 32'd0;
        shadow_accum = 32'd0;
        shadow_hex_done = 1'b0;
        shadow_name_size = 32'd0;
        shadow_file_size = 32'd0;
        shadow_type = 4'd0;
        shadow_offset = 2'd0;
        shadow_trailer_ok = 1'b1;
        shadow_entry = 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_entries();
        test_empty_regions();
        test_hex_fields();
        test_near_trailers();
        test_random_archive();
        test_halt();

        // Drain the output, then give stray transfers a chance to show up.
        s_axis_tvalid <= 1'b0;
        while (expected_tags.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d entries in %0d archive bytes, ending on %s.", entries_sent,
                 bytes_sent, ended_on_trailer ? "a trailer entry" : "a broken magic");
        $display("Checked %0d tagged bytes, %0d mismatches.", tags_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
